// ===== rtl/core/ssmp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the scored set maximum picker.
// Holds command codes, fixed field widths and the store control struct.
// Depends on nothing.
package ssmp_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int SCORE_BITS_DEF = 8;

  localparam int CMD_W    = 3;
  localparam int SPOT_W   = 6;
  localparam int DELTA_W  = 8;
  localparam int RAND_W   = 16;
  localparam int SCORE_W  = 8;
  localparam int PICKED_W = 6;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PICK    = 3'd5;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic clear_all;
    logic wr_en;
  } store_ctl_t;

endpackage

// ===== rtl/core/ssmp_store.sv =====
`timescale 1ns / 1ps
// Score memory with one write and one registered read port.
// Per-entry valid bits make unwritten or cleared entries read as zero.
// Depends on ssmp_pkg.
module ssmp_store #(
  parameter int ENTRIES    = ssmp_pkg::ENTRIES_DEF,
  parameter int SCORE_BITS = ssmp_pkg::SCORE_BITS_DEF,
  localparam int IDX_W     = $clog2(ENTRIES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ssmp_pkg::store_ctl_t   ctl,
  input  logic [IDX_W-1:0]       waddr,
  input  logic [SCORE_BITS-1:0]  wdata,
  input  logic [IDX_W-1:0]       raddr,
  output logic [SCORE_BITS-1:0]  rdata
);
  import ssmp_pkg::*;

  logic [SCORE_BITS-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0]    valid;
  logic [SCORE_BITS-1:0] rd_word;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    rd_word <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[raddr];
      if (ctl.clear_all) begin
        valid <= '0;
      end else if (ctl.wr_en) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

// ===== rtl/core/ssmp_alu.sv =====
`timescale 1ns / 1ps
// Shared adder and subtracter used for updates and all score comparisons.
// The top result bit is the carry on add and the borrow on subtract.
// Depends on ssmp_pkg.
module ssmp_alu #(
  parameter int SCORE_BITS = ssmp_pkg::SCORE_BITS_DEF,
  localparam int OP_W = (SCORE_BITS > ssmp_pkg::DELTA_W) ? SCORE_BITS : ssmp_pkg::DELTA_W
) (
  input  logic            op,
  input  logic [OP_W-1:0] a,
  input  logic [OP_W-1:0] b,
  output logic [OP_W:0]   res
);
  import ssmp_pkg::*;

  always_comb begin
    if (op == ALU_SUB) begin
      res = {1'b0, a} - {1'b0, b};
    end else begin
      res = {1'b0, a} + {1'b0, b};
    end
  end

endmodule

// ===== rtl/core/ssmp_div.sv =====
`timescale 1ns / 1ps
// Restoring modulo unit, one dividend bit per cycle.
// Gives the random value modulo the member count for the pick command.
// Depends on ssmp_pkg.
module ssmp_div #(
  parameter int ENTRIES = ssmp_pkg::ENTRIES_DEF,
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ssmp_pkg::RAND_W-1:0] dividend,
  input  logic [CNT_W-1:0]            divisor,
  output logic                        done,
  output logic [CNT_W-1:0]            rem
);
  import ssmp_pkg::*;

  localparam int STEP_W = $clog2(RAND_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [RAND_W-1:0] dvd;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;

  assign shifted = {rem, dvd[RAND_W-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(RAND_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= trial[CNT_W] ? shifted[CNT_W-1:0] : trial[CNT_W-1:0];
      dvd <= dvd << 1;
    end
  end

endmodule

// ===== rtl/core/ssmp_ctrl.sv =====
`timescale 1ns / 1ps
// Command sequencer: read-modify-write of one entry, and the three scans of a pick.
// Drives the score store, the shared adder and the modulo unit.
// Depends on ssmp_pkg.
module ssmp_ctrl #(
  parameter int ENTRIES    = ssmp_pkg::ENTRIES_DEF,
  parameter int SCORE_BITS = ssmp_pkg::SCORE_BITS_DEF,
  localparam int IDX_W = $clog2(ENTRIES),
  localparam int CNT_W = $clog2(ENTRIES + 1),
  localparam int OP_W  = (SCORE_BITS > ssmp_pkg::DELTA_W) ? SCORE_BITS : ssmp_pkg::DELTA_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ssmp_pkg::CMD_W-1:0]   cmd,
  input  logic [ssmp_pkg::SPOT_W-1:0]  spot,
  input  logic [ssmp_pkg::DELTA_W-1:0] delta,
  input  logic [ssmp_pkg::RAND_W-1:0]  random,
  output logic                         res_valid,
  input  logic                         res_take,
  output logic                         res_member,
  output logic [SCORE_BITS-1:0]        res_score,
  output logic [IDX_W-1:0]             res_picked,
  output logic                         res_ok,
  output logic [CNT_W-1:0]             members,
  output ssmp_pkg::store_ctl_t         st_ctl,
  output logic [IDX_W-1:0]             st_waddr,
  output logic [SCORE_BITS-1:0]        st_wdata,
  output logic [IDX_W-1:0]             st_raddr,
  input  logic [SCORE_BITS-1:0]        st_rdata,
  output logic                         alu_op,
  output logic [OP_W-1:0]              alu_a,
  output logic [OP_W-1:0]              alu_b,
  input  logic [OP_W:0]                alu_res,
  output logic                         div_start,
  output logic [ssmp_pkg::RAND_W-1:0]  div_dividend,
  output logic [CNT_W-1:0]             div_divisor,
  input  logic                         div_done,
  input  logic [CNT_W-1:0]             div_rem
);
  import ssmp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MODIFY = 3'd1;
  localparam logic [2:0] S_MAX    = 3'd2;
  localparam logic [2:0] S_DROP   = 3'd3;
  localparam logic [2:0] S_MOD    = 3'd4;
  localparam logic [2:0] S_SEL    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]            state;
  logic [CMD_W-1:0]      cmd_q;
  logic [IDX_W-1:0]      spot_q;
  logic [DELTA_W-1:0]    delta_q;
  logic [RAND_W-1:0]     random_q;
  logic [CNT_W-1:0]      ctr;
  logic [CNT_W-1:0]      seen;
  logic [SCORE_BITS-1:0] top;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_live;
  logic [CNT_W-1:0]      members_next;
  logic                  scan_issue;
  logic                  accept;
  logic                  spot_ok;
  logic                  cur_nz;

  assign accept       = in_valid && (state == S_IDLE);
  assign in_stall     = (state != S_IDLE);
  assign res_valid    = (state == S_DONE);
  assign spot_ok      = (int'(spot) < ENTRIES);
  assign cur_nz       = |st_rdata;
  assign div_dividend = random_q;
  assign div_divisor  = members_next;

  always_comb begin
    st_ctl       = '0;
    st_waddr     = rd_idx;
    st_wdata     = '0;
    st_raddr     = ctr[IDX_W-1:0];
    alu_op       = ALU_SUB;
    alu_a        = '0;
    alu_b        = '0;
    members_next = members;
    scan_issue   = 1'b0;
    div_start    = 1'b0;
    unique case (state)
      S_IDLE: begin
        st_raddr = IDX_W'(spot);
        if (accept && (cmd == CMD_CLEAR)) begin
          st_ctl.clear_all = 1'b1;
          members_next     = '0;
        end
      end
      S_MODIFY: begin
        st_waddr = spot_q;
        alu_a    = OP_W'(st_rdata);
        alu_b    = OP_W'(delta_q);
        case (cmd_q)
          CMD_ADD: begin
            alu_op       = ALU_ADD;
            st_ctl.wr_en = 1'b1;
            st_wdata     = (|alu_res[OP_W:SCORE_BITS]) ? '1 : alu_res[SCORE_BITS-1:0];
            if (!cur_nz && (|st_wdata)) begin
              members_next = members + CNT_W'(1);
            end
          end
          CMD_SUB: begin
            if ((|delta_q) && !alu_res[OP_W]) begin
              st_ctl.wr_en = 1'b1;
              st_wdata     = alu_res[SCORE_BITS-1:0];
              if (!(|st_wdata)) begin
                members_next = members - CNT_W'(1);
              end
            end
          end
          CMD_DISABLE: begin
            st_ctl.wr_en = 1'b1;
            if (cur_nz) begin
              members_next = members - CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
      S_MAX: begin
        scan_issue = (ctr != CNT_W'(ENTRIES));
        alu_a      = OP_W'(top);
        alu_b      = OP_W'(st_rdata);
      end
      S_DROP: begin
        scan_issue = (ctr != CNT_W'(ENTRIES));
        alu_a      = OP_W'(st_rdata);
        alu_b      = OP_W'(top);
        if (rd_live && alu_res[OP_W]) begin
          st_ctl.wr_en = 1'b1;
          if (cur_nz) begin
            members_next = members - CNT_W'(1);
          end
        end
        div_start = !scan_issue;
      end
      S_SEL: begin
        scan_issue = (ctr != CNT_W'(ENTRIES));
      end
      S_MOD, S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      members <= '0;
      rd_live <= 1'b0;
      ctr     <= '0;
      seen    <= '0;
      res_ok  <= 1'b0;
      cmd_q   <= CMD_CLEAR;
    end else begin
      members <= members_next;
      rd_live <= scan_issue;
      if (scan_issue) begin
        ctr <= ctr + CNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q  <= cmd;
            res_ok <= 1'b0;
            ctr    <= '0;
            seen   <= '0;
            unique case (cmd) inside
              CMD_ADD, CMD_SUB, CMD_DISABLE, CMD_QUERY: begin
                state <= spot_ok ? S_MODIFY : S_DONE;
              end
              CMD_PICK: begin
                state <= (members != '0) ? S_MAX : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MODIFY: begin
          state <= S_DONE;
        end
        S_MAX: begin
          if (!scan_issue) begin
            ctr   <= '0;
            state <= S_DROP;
          end
        end
        S_DROP: begin
          if (!scan_issue) begin
            ctr   <= '0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (div_done) begin
            state <= S_SEL;
          end
        end
        S_SEL: begin
          if (rd_live && cur_nz && !res_ok) begin
            if (seen == div_rem) begin
              res_ok <= 1'b1;
            end
            seen <= seen + CNT_W'(1);
          end
          if (!scan_issue) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= ctr[IDX_W-1:0];
    if (accept) begin
      spot_q     <= IDX_W'(spot);
      delta_q    <= delta;
      random_q   <= random;
      res_member <= 1'b0;
      res_score  <= '0;
      res_picked <= '0;
      top        <= '0;
    end
    if ((state == S_MODIFY) && (cmd_q == CMD_QUERY)) begin
      res_score  <= st_rdata;
      res_member <= cur_nz;
    end
    if ((state == S_MAX) && rd_live && alu_res[OP_W]) begin
      top <= st_rdata;
    end
    if ((state == S_SEL) && rd_live && cur_nz && !res_ok && (seen == div_rem)) begin
      res_picked <= rd_idx;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    members <= CNT_W'(ENTRIES))
    else $error("Member count exceeds the number of entries.");

  a_ok_only_pick: assert property (@(posedge clk) disable iff (rst)
    res_ok |-> (cmd_q == CMD_PICK))
    else $error("Pick success flagged for an item that is not a pick.");

  a_div_in_mod: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_MOD))
    else $error("Modulo unit finished outside its wait state.");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_CLEAR)) |=> (members == '0))
    else $error("Member count not zero after a clear.");

endmodule

// ===== rtl/core/scored_set_max_picker_core.sv =====
`timescale 1ns / 1ps
// Scored set maximum picker: top level with the output register.
// Instantiates ssmp_ctrl, ssmp_store, ssmp_alu and ssmp_div; depends on ssmp_pkg.
//
// Usage: an item (cmd, spot, delta, random) is taken when in_valid is high and
// in_stall is low; each item gives exactly one result item on the output
// channel, taken when out_valid is high and out_stall is low.
// The block works on one item at a time and holds in_stall high until the
// result has been moved into the output register.
// From acceptance to out_valid: clear, unknown codes and out-of-range spots go
// straight to the result state; add, subtract, disable and query first pass the
// read-modify-write state; a pick makes two passes over the score memory at
// one read per cycle, waits on the bit-serial modulo unit and then makes a third
// pass to select its entry. Every result then moves into the output register.
// A pick on an empty set goes straight to the result state.
// With no stall, the next item is taken in the cycle after a result reaches the
// output register.
// While the receiver stalls, the result stays in the output register and one
// further item can be worked on; its result then waits inside the sequencer.
// Synchronous reset empties the set at once through per-entry valid bits and
// clears both channels; no clearing pass is needed.
module scored_set_max_picker_core #(
  parameter int ENTRIES    = ssmp_pkg::ENTRIES_DEF,
  parameter int SCORE_BITS = ssmp_pkg::SCORE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ssmp_pkg::CMD_W-1:0]    cmd,
  input  logic [ssmp_pkg::SPOT_W-1:0]   spot,
  input  logic [ssmp_pkg::DELTA_W-1:0]  delta,
  input  logic [ssmp_pkg::RAND_W-1:0]   random,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          member,
  output logic [ssmp_pkg::SCORE_W-1:0]  score,
  output logic [ssmp_pkg::PICKED_W-1:0] picked,
  output logic                          pick_ok,
  output logic [ssmp_pkg::COUNT_W-1:0]  active_count,
  output logic                          empty_res
);
  import ssmp_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int OP_W  = (SCORE_BITS > DELTA_W) ? SCORE_BITS : DELTA_W;

  logic                  res_valid;
  logic                  res_take;
  logic                  res_member;
  logic [SCORE_BITS-1:0] res_score;
  logic [IDX_W-1:0]      res_picked;
  logic                  res_ok;
  logic [CNT_W-1:0]      members;
  store_ctl_t            st_ctl;
  logic [IDX_W-1:0]      st_waddr;
  logic [SCORE_BITS-1:0] st_wdata;
  logic [IDX_W-1:0]      st_raddr;
  logic [SCORE_BITS-1:0] st_rdata;
  logic                  alu_op;
  logic [OP_W-1:0]       alu_a;
  logic [OP_W-1:0]       alu_b;
  logic [OP_W:0]         alu_res;
  logic                  div_start;
  logic [RAND_W-1:0]     div_dividend;
  logic [CNT_W-1:0]      div_divisor;
  logic                  div_done;
  logic [CNT_W-1:0]      div_rem;

  ssmp_ctrl #(
    .ENTRIES    (ENTRIES),
    .SCORE_BITS (SCORE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .spot         (spot),
    .delta        (delta),
    .random       (random),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res_member   (res_member),
    .res_score    (res_score),
    .res_picked   (res_picked),
    .res_ok       (res_ok),
    .members      (members),
    .st_ctl       (st_ctl),
    .st_waddr     (st_waddr),
    .st_wdata     (st_wdata),
    .st_raddr     (st_raddr),
    .st_rdata     (st_rdata),
    .alu_op       (alu_op),
    .alu_a        (alu_a),
    .alu_b        (alu_b),
    .alu_res      (alu_res),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_rem      (div_rem)
  );

  ssmp_store #(
    .ENTRIES    (ENTRIES),
    .SCORE_BITS (SCORE_BITS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (st_ctl),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  ssmp_alu #(
    .SCORE_BITS (SCORE_BITS)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  ssmp_div #(
    .ENTRIES (ENTRIES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      member       <= res_member;
      score        <= SCORE_W'(res_score);
      picked       <= PICKED_W'(res_picked);
      pick_ok      <= res_ok;
      active_count <= COUNT_W'(members);
      empty_res    <= (members == '0);
    end
  end

endmodule
